// ===== rtl/core/vau_pkg.sv =====
// Shared codes, tables and conversion functions for the vertex attribute unpacker.
package vau_pkg;

	// Declaration type codes.
	localparam logic [4:0] FMT_FLOAT1   = 5'd0;
	localparam logic [4:0] FMT_FLOAT2   = 5'd1;
	localparam logic [4:0] FMT_FLOAT3   = 5'd2;
	localparam logic [4:0] FMT_FLOAT4   = 5'd3;
	localparam logic [4:0] FMT_COLOR    = 5'd4;
	localparam logic [4:0] FMT_UBYTE4   = 5'd5;
	localparam logic [4:0] FMT_SHORT2   = 5'd6;
	localparam logic [4:0] FMT_SHORT4   = 5'd7;
	localparam logic [4:0] FMT_UBYTE4N  = 5'd8;
	localparam logic [4:0] FMT_SHORT2N  = 5'd9;
	localparam logic [4:0] FMT_SHORT4N  = 5'd10;
	localparam logic [4:0] FMT_USHORT2N = 5'd11;
	localparam logic [4:0] FMT_USHORT4N = 5'd12;
	localparam logic [4:0] FMT_UDEC3    = 5'd13;
	localparam logic [4:0] FMT_DEC3N    = 5'd14;
	localparam logic [4:0] FMT_HALF2    = 5'd15;
	localparam logic [4:0] FMT_HALF4    = 5'd16;

	// Decode modes.
	localparam logic ACT_VECTOR = 1'b0;
	localparam logic ACT_COLOR  = 1'b1;

	// Conversion applied by one component lane.
	typedef logic [2:0] lane_kind_t;
	localparam lane_kind_t LK_ZERO    = 3'd0;
	localparam lane_kind_t LK_WORD    = 3'd1;
	localparam lane_kind_t LK_BYTEN   = 3'd2;
	localparam lane_kind_t LK_SHORT   = 3'd3;
	localparam lane_kind_t LK_SHORTN  = 3'd4;
	localparam lane_kind_t LK_USHORTN = 3'd5;
	localparam lane_kind_t LK_HALF    = 3'd6;
	localparam lane_kind_t LK_ONE     = 3'd7;

	// Period of the repeating fraction for a divisor of the form 2^n - 1.
	typedef logic [1:0] rep_sel_t;
	localparam rep_sel_t RS_8  = 2'd0;
	localparam rep_sel_t RS_15 = 2'd1;
	localparam rep_sel_t RS_16 = 2'd2;

	localparam logic [31:0] ONE_BITS     = 32'h3F80_0000;
	localparam logic [30:0] ONE_EPS_BITS = 31'h3F80_0100;

	// Size in bytes of each format; zero for an unknown code.
	function automatic logic [4:0] fmt_size(input logic [4:0] fmt);
		logic [4:0] s;
		case (fmt)
			FMT_FLOAT1:   s = 5'd4;
			FMT_FLOAT2:   s = 5'd8;
			FMT_FLOAT3:   s = 5'd12;
			FMT_FLOAT4:   s = 5'd16;
			FMT_COLOR:    s = 5'd4;
			FMT_UBYTE4:   s = 5'd4;
			FMT_SHORT2:   s = 5'd4;
			FMT_SHORT4:   s = 5'd8;
			FMT_UBYTE4N:  s = 5'd4;
			FMT_SHORT2N:  s = 5'd4;
			FMT_SHORT4N:  s = 5'd8;
			FMT_USHORT2N: s = 5'd4;
			FMT_USHORT4N: s = 5'd8;
			FMT_UDEC3:    s = 5'd4;
			FMT_DEC3N:    s = 5'd4;
			FMT_HALF2:    s = 5'd4;
			FMT_HALF4:    s = 5'd8;
			default:      s = 5'd0;
		endcase
		return s;
	endfunction

	// Leading zero count of a nonzero 16-bit value.
	function automatic logic [3:0] clz16(input logic [15:0] v);
		logic [3:0] n;
		n = 4'd15;
		for (int i = 0; i < 16; i++) begin
			if (v[i]) begin
				n = 4'(15 - i);
			end
		end
		return n;
	endfunction

	// r / (2^n - 1) for r below the divisor is the n-bit pattern of r repeated forever.
	function automatic logic [63:0] rep_pattern(input logic [15:0] r, input rep_sel_t sel);
		logic [63:0] p;
		p = '0;
		for (int i = 0; i < 64; i++) begin
			case (sel)
				RS_8:    p[63 - i] = r[7 - (i % 8)];
				RS_15:   p[63 - i] = r[14 - (i % 15)];
				default: p[63 - i] = r[15 - (i % 16)];
			endcase
		end
		return p;
	endfunction

	// Normalize a nonzero repeating fraction and round it to single precision.
	// The pattern never terminates, so the sticky bit is always set and a tie
	// cannot occur: round up whenever the guard bit is set.
	function automatic logic [30:0] frac_to_single(input logic [63:0] p, input logic [3:0] lz);
		logic [63:0] sh;
		logic [24:0] sum;
		logic [30:0] res;
		sh = p << lz;
		sum = {1'b0, sh[63:40]} + 25'(sh[39]);
		if (sum[24]) begin
			res = {8'd127 - {4'd0, lz}, 23'd0};
		end else begin
			res = {8'd126 - {4'd0, lz}, sum[22:0]};
		end
		return res;
	endfunction

	// Unsigned byte divided by 255.
	function automatic logic [31:0] byte_norm(input logic [7:0] v);
		logic [31:0] res;
		if (v == 8'd0) begin
			res = 32'd0;
		end else if (v == 8'hFF) begin
			res = ONE_BITS;
		end else begin
			res = {1'b0, frac_to_single(rep_pattern({8'd0, v}, RS_8), clz16({v, 8'd0}))};
		end
		return res;
	endfunction

	// Signed short divided by 32767.
	function automatic logic [31:0] short_norm(input logic [15:0] v);
		logic neg;
		logic [15:0] m;
		logic [31:0] res;
		neg = v[15];
		m = neg ? 16'(-v) : v;
		if (m == 16'd0) begin
			res = 32'd0;
		end else if (m == 16'h8000) begin
			res = {neg, ONE_EPS_BITS};
		end else if (m == 16'h7FFF) begin
			res = {neg, ONE_BITS[30:0]};
		end else begin
			res = {neg, frac_to_single(rep_pattern(m, RS_15), clz16({m[14:0], 1'b0}))};
		end
		return res;
	endfunction

	// Unsigned short divided by 65535.
	function automatic logic [31:0] ushort_norm(input logic [15:0] v);
		logic [31:0] res;
		if (v == 16'd0) begin
			res = 32'd0;
		end else if (v == 16'hFFFF) begin
			res = ONE_BITS;
		end else begin
			res = {1'b0, frac_to_single(rep_pattern(v, RS_16), clz16(v))};
		end
		return res;
	endfunction

	// Signed short converted exactly to single precision.
	function automatic logic [31:0] short_int(input logic [15:0] v);
		logic neg;
		logic [15:0] m;
		logic [15:0] sh;
		logic [3:0] lz;
		logic [31:0] res;
		neg = v[15];
		m = neg ? 16'(-v) : v;
		lz = clz16(m);
		sh = m << lz;
		if (m == 16'd0) begin
			res = 32'd0;
		end else begin
			res = {neg, 8'd142 - {4'd0, lz}, sh[14:0], 8'd0};
		end
		return res;
	endfunction

	// Half precision widened exactly to single precision.
	function automatic logic [31:0] half_to_single(input logic [15:0] h);
		logic [4:0] e;
		logic [9:0] m;
		logic [3:0] lz;
		logic [15:0] t;
		logic [31:0] res;
		e = h[14:10];
		m = h[9:0];
		lz = clz16({m, 6'd0});
		t = {6'd0, m} << (lz + 4'd1);
		if (e == 5'd0) begin
			if (m == 10'd0) begin
				res = {h[15], 31'd0};
			end else begin
				res = {h[15], 8'd112 - {4'd0, lz}, t[9:0], 13'd0};
			end
		end else if (e == 5'h1F) begin
			res = {h[15], 8'hFF, m, 13'd0};
		end else begin
			res = {h[15], {3'd0, e} + 8'd112, m, 13'd0};
		end
		return res;
	endfunction

endpackage

// ===== rtl/core/vau_lane.sv =====
// One component lane: converts a selected source field to a single-precision word.
module vau_lane (
	input  vau_pkg::lane_kind_t kind,
	input  logic [31:0]         word,
	input  logic [15:0]         half,
	input  logic [7:0]          byte_val,
	output logic [31:0]         comp
);

	// Select the conversion for this lane.
	always_comb begin
		case (kind)
			vau_pkg::LK_WORD:    comp = word;
			vau_pkg::LK_BYTEN:   comp = vau_pkg::byte_norm(byte_val);
			vau_pkg::LK_SHORT:   comp = vau_pkg::short_int(half);
			vau_pkg::LK_SHORTN:  comp = vau_pkg::short_norm(half);
			vau_pkg::LK_USHORTN: comp = vau_pkg::ushort_norm(half);
			vau_pkg::LK_HALF:    comp = vau_pkg::half_to_single(half);
			vau_pkg::LK_ONE:     comp = vau_pkg::ONE_BITS;
			default:             comp = 32'd0;
		endcase
	end

endmodule

// ===== rtl/core/vertex_attribute_unpack.sv =====
// Top level of the vertex attribute unpacker: input register, decode lanes, output register.
//
//  channel | fields                                      | handshake
//  in      | action, attr_format, raw_low, raw_high      | in_valid / in_stall
//  out     | comp_x..comp_w, size_bytes, format_error    | out_valid / out_stall
//
// One word per cycle is accepted while in_stall is low.
// The rate is set by the single conversion pass between the input and output registers.
// Reset clears only the two stage valid flags.
// A stall on the output holds both stages; the input stalls only when both are full.
module vertex_attribute_unpack (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [4:0]  attr_format,
	input  logic [63:0] raw_low,
	input  logic [63:0] raw_high,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] comp_x,
	output logic [31:0] comp_y,
	output logic [31:0] comp_z,
	output logic [31:0] comp_w,
	output logic [4:0]  size_bytes,
	output logic        format_error
);

	logic        valid_s1;
	logic        action_s1;
	logic [4:0]  format_s1;
	logic [63:0] low_s1;
	logic [63:0] high_s1;
	logic        valid_s2;
	logic [31:0] comp_s2 [4];
	logic [4:0]  size_s2;
	logic        error_s2;

	logic               out_free;
	logic               load_s1;
	vau_pkg::lane_kind_t kind [4];
	logic               err;
	logic [31:0]        word [4];
	logic [15:0]        half [4];
	logic [7:0]         byte_sel [4];
	logic [31:0]        comp [4];

	// Pipeline advance control.
	assign out_free = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !out_free;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!valid_s1 || out_free) begin
				valid_s1 <= in_valid;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (load_s1) begin
			action_s1 <= action;
			format_s1 <= attr_format;
			low_s1    <= raw_low;
			high_s1   <= raw_high;
		end
	end

	// Source fields for each lane; color bytes come in the order 2, 1, 0, 3.
	always_comb begin
		word[0] = low_s1[31:0];
		word[1] = low_s1[63:32];
		word[2] = high_s1[31:0];
		word[3] = high_s1[63:32];
		half[0] = low_s1[15:0];
		half[1] = low_s1[31:16];
		half[2] = low_s1[47:32];
		half[3] = low_s1[63:48];
		byte_sel[0] = low_s1[23:16];
		byte_sel[1] = low_s1[15:8];
		byte_sel[2] = low_s1[7:0];
		byte_sel[3] = low_s1[31:24];
	end

	// Decode the format into a conversion for each lane.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			kind[i] = vau_pkg::LK_ZERO;
		end
		err = 1'b0;
		if (action_s1 == vau_pkg::ACT_VECTOR) begin
			case (format_s1)
				vau_pkg::FMT_FLOAT1: kind[0] = vau_pkg::LK_WORD;
				vau_pkg::FMT_FLOAT2: begin
					kind[0] = vau_pkg::LK_WORD;
					kind[1] = vau_pkg::LK_WORD;
				end
				vau_pkg::FMT_FLOAT3, vau_pkg::FMT_FLOAT4: begin
					for (int i = 0; i < 3; i++) kind[i] = vau_pkg::LK_WORD;
				end
				vau_pkg::FMT_COLOR: begin
					for (int i = 0; i < 3; i++) kind[i] = vau_pkg::LK_BYTEN;
				end
				vau_pkg::FMT_SHORT2: begin
					kind[0] = vau_pkg::LK_SHORT;
					kind[1] = vau_pkg::LK_SHORT;
				end
				vau_pkg::FMT_SHORT4: begin
					for (int i = 0; i < 3; i++) kind[i] = vau_pkg::LK_SHORT;
				end
				vau_pkg::FMT_SHORT2N: begin
					kind[0] = vau_pkg::LK_SHORTN;
					kind[1] = vau_pkg::LK_SHORTN;
				end
				vau_pkg::FMT_SHORT4N: begin
					for (int i = 0; i < 3; i++) kind[i] = vau_pkg::LK_SHORTN;
				end
				vau_pkg::FMT_USHORT2N: begin
					kind[0] = vau_pkg::LK_USHORTN;
					kind[1] = vau_pkg::LK_USHORTN;
				end
				vau_pkg::FMT_USHORT4N: begin
					for (int i = 0; i < 3; i++) kind[i] = vau_pkg::LK_USHORTN;
				end
				vau_pkg::FMT_HALF2: begin
					kind[0] = vau_pkg::LK_HALF;
					kind[1] = vau_pkg::LK_HALF;
				end
				vau_pkg::FMT_HALF4: begin
					for (int i = 0; i < 3; i++) kind[i] = vau_pkg::LK_HALF;
				end
				default: err = 1'b1;
			endcase
		end else begin
			case (format_s1)
				vau_pkg::FMT_FLOAT3: begin
					for (int i = 0; i < 3; i++) kind[i] = vau_pkg::LK_WORD;
					kind[3] = vau_pkg::LK_ONE;
				end
				vau_pkg::FMT_FLOAT4: begin
					for (int i = 0; i < 4; i++) kind[i] = vau_pkg::LK_WORD;
				end
				vau_pkg::FMT_HALF4: begin
					for (int i = 0; i < 4; i++) kind[i] = vau_pkg::LK_HALF;
				end
				vau_pkg::FMT_COLOR: begin
					for (int i = 0; i < 4; i++) kind[i] = vau_pkg::LK_BYTEN;
				end
				default: err = 1'b1;
			endcase
		end
	end

	// Four conversion lanes.
	for (genvar g = 0; g < 4; g++) begin : g_lane
		vau_lane u_lane (
			.kind     (kind[g]),
			.word     (word[g]),
			.half     (half[g]),
			.byte_val (byte_sel[g]),
			.comp     (comp[g])
		);
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			for (int i = 0; i < 4; i++) begin
				comp_s2[i] <= comp[i];
			end
			size_s2  <= vau_pkg::fmt_size(format_s1);
			error_s2 <= err;
		end
	end

	assign out_valid    = valid_s2;
	assign comp_x       = comp_s2[0];
	assign comp_y       = comp_s2[1];
	assign comp_z       = comp_s2[2];
	assign comp_w       = comp_s2[3];
	assign size_bytes   = size_s2;
	assign format_error = error_s2;

endmodule

// ===== rtl/core/vau_checker.sv =====
// Port-level checks for the vertex attribute unpacker and their binding.
module vau_port_props (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] comp_x,
	input logic [31:0] comp_y,
	input logic [31:0] comp_z,
	input logic [31:0] comp_w,
	input logic [4:0]  size_bytes,
	input logic        format_error
);

	// A stalled result word stays valid, and its x and w components stay in place.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(comp_x) && $stable(comp_w))
		else $error("stalled result changed");

	// An error word carries zero components.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && format_error |->
			comp_x == 32'd0 && comp_y == 32'd0 && comp_z == 32'd0 && comp_w == 32'd0)
		else $error("error word has nonzero components");

	// A supported format always has a known size.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !format_error |-> size_bytes != 5'd0)
		else $error("supported format with zero size");

	// The input stalls only behind a stalled full output.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

endmodule

bind vertex_attribute_unpack vau_port_props u_vau_port_props (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.comp_x       (comp_x),
	.comp_y       (comp_y),
	.comp_z       (comp_z),
	.comp_w       (comp_w),
	.size_bytes   (size_bytes),
	.format_error (format_error)
);

// ===== tb/vau_checker.sv =====
// Checker for the vertex attribute unpacker: predicts each accepted word and compares results.
`timescale 1ns / 1ps
module vau_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        action,
	input  logic [4:0]  attr_format,
	input  logic [63:0] raw_low,
	input  logic [63:0] raw_high,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] comp_x,
	input  logic [31:0] comp_y,
	input  logic [31:0] comp_z,
	input  logic [31:0] comp_w,
	input  logic [4:0]  size_bytes,
	input  logic        format_error,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] w;
		logic [4:0]  size;
		logic        err;
	} attr_result_t;

	attr_result_t unpacked_q[$];

	// Exact quotient n / d rounded to nearest even single precision.
	function automatic logic [31:0] quot_single(input logic neg, input longint unsigned n,
			input longint unsigned d);
		longint unsigned num, q, r;
		int k;
		if (n == 0) begin
			return 32'd0;
		end
		k = 0;
		num = n;
		q = num / d;
		while (q < 64'h80_0000) begin
			k++;
			num = n << k;
			q = num / d;
		end
		r = num % d;
		if (2 * r > d || (2 * r == d && q[0])) begin
			q++;
		end
		if (q == 64'h100_0000) begin
			q = q >> 1;
			k--;
		end
		return {neg, 8'(150 - k), q[22:0]};
	endfunction

	// Half precision widened to single precision.
	function automatic logic [31:0] widen_half(input logic [15:0] h);
		logic [10:0] m;
		int ex;
		m = {1'b0, h[9:0]};
		if (h[14:10] == 5'd0) begin
			if (m == 11'd0) begin
				return {h[15], 31'd0};
			end
			ex = 113;
			while (!m[10]) begin
				m = m << 1;
				ex--;
			end
			return {h[15], 8'(ex), m[9:0], 13'd0};
		end
		if (h[14:10] == 5'h1F) begin
			return {h[15], 8'hFF, h[9:0], 13'd0};
		end
		return {h[15], 8'(h[14:10] + 112), h[9:0], 13'd0};
	endfunction

	function automatic logic [31:0] signed_short(input logic [15:0] v, input bit norm);
		logic [16:0] m;
		m = v[15] ? 17'(17'h1_0000 - v) : {1'b0, v};
		return quot_single(v[15], 64'(m), norm ? 64'd32767 : 64'd1);
	endfunction

	function automatic attr_result_t unpack_attr(input logic act, input logic [4:0] fmt,
			input logic [127:0] raw);
		attr_result_t res;
		logic [31:0] c[4];
		logic ok;
		for (int i = 0; i < 4; i++) begin
			c[i] = 32'd0;
		end
		ok = 1'b1;
		if (act == vau_pkg::ACT_VECTOR) begin
			case (fmt)
				vau_pkg::FMT_FLOAT1: c[0] = raw[31:0];
				vau_pkg::FMT_FLOAT2: begin
					c[0] = raw[31:0];
					c[1] = raw[63:32];
				end
				vau_pkg::FMT_FLOAT3, vau_pkg::FMT_FLOAT4: begin
					for (int i = 0; i < 3; i++) c[i] = raw[32*i +: 32];
				end
				vau_pkg::FMT_COLOR: begin
					c[0] = quot_single(1'b0, 64'(raw[23:16]), 64'd255);
					c[1] = quot_single(1'b0, 64'(raw[15:8]), 64'd255);
					c[2] = quot_single(1'b0, 64'(raw[7:0]), 64'd255);
				end
				vau_pkg::FMT_SHORT2, vau_pkg::FMT_SHORT4: begin
					for (int i = 0; i < (fmt == vau_pkg::FMT_SHORT2 ? 2 : 3); i++)
						c[i] = signed_short(raw[16*i +: 16], 1'b0);
				end
				vau_pkg::FMT_SHORT2N, vau_pkg::FMT_SHORT4N: begin
					for (int i = 0; i < (fmt == vau_pkg::FMT_SHORT2N ? 2 : 3); i++)
						c[i] = signed_short(raw[16*i +: 16], 1'b1);
				end
				vau_pkg::FMT_USHORT2N, vau_pkg::FMT_USHORT4N: begin
					for (int i = 0; i < (fmt == vau_pkg::FMT_USHORT2N ? 2 : 3); i++)
						c[i] = quot_single(1'b0, 64'(raw[16*i +: 16]), 64'd65535);
				end
				vau_pkg::FMT_HALF2, vau_pkg::FMT_HALF4: begin
					for (int i = 0; i < (fmt == vau_pkg::FMT_HALF2 ? 2 : 3); i++)
						c[i] = widen_half(raw[16*i +: 16]);
				end
				default: ok = 1'b0;
			endcase
		end else begin
			case (fmt)
				vau_pkg::FMT_FLOAT3: begin
					for (int i = 0; i < 3; i++) c[i] = raw[32*i +: 32];
					c[3] = vau_pkg::ONE_BITS;
				end
				vau_pkg::FMT_FLOAT4: begin
					for (int i = 0; i < 4; i++) c[i] = raw[32*i +: 32];
				end
				vau_pkg::FMT_HALF4: begin
					for (int i = 0; i < 4; i++) c[i] = widen_half(raw[16*i +: 16]);
				end
				vau_pkg::FMT_COLOR: begin
					c[0] = quot_single(1'b0, 64'(raw[23:16]), 64'd255);
					c[1] = quot_single(1'b0, 64'(raw[15:8]), 64'd255);
					c[2] = quot_single(1'b0, 64'(raw[7:0]), 64'd255);
					c[3] = quot_single(1'b0, 64'(raw[31:24]), 64'd255);
				end
				default: ok = 1'b0;
			endcase
		end
		res.x = ok ? c[0] : 32'd0;
		res.y = ok ? c[1] : 32'd0;
		res.z = ok ? c[2] : 32'd0;
		res.w = ok ? c[3] : 32'd0;
		res.size = vau_pkg::fmt_size(fmt);
		res.err = !ok;
		return res;
	endfunction

	assign pending = unpacked_q.size();

	// Watch both channels; predict on input acceptance, compare on output acceptance.
	always @(posedge clk or negedge arst_n) begin
		attr_result_t exp_r;
		int errs;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			errs = 0;
			if (in_valid && !in_stall) begin
				unpacked_q.push_back(unpack_attr(action, attr_format, {raw_high, raw_low}));
			end
			if (out_valid && !out_stall) begin
				if (unpacked_q.size() == 0) begin
					$error("unexpected output word");
					errs++;
				end else begin
					exp_r = unpacked_q.pop_front();
					if (comp_x !== exp_r.x) begin
						$error("comp_x expected %h actual %h", exp_r.x, comp_x);
						errs++;
					end
					if (comp_y !== exp_r.y) begin
						$error("comp_y expected %h actual %h", exp_r.y, comp_y);
						errs++;
					end
					if (comp_z !== exp_r.z) begin
						$error("comp_z expected %h actual %h", exp_r.z, comp_z);
						errs++;
					end
					if (comp_w !== exp_r.w) begin
						$error("comp_w expected %h actual %h", exp_r.w, comp_w);
						errs++;
					end
					if (size_bytes !== exp_r.size) begin
						$error("size_bytes expected %0d actual %0d", exp_r.size, size_bytes);
						errs++;
					end
					if (format_error !== exp_r.err) begin
						$error("format_error expected %b actual %b", exp_r.err, format_error);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Top of the vertex attribute unpacker testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        action;
	logic [4:0]  attr_format;
	logic [63:0] raw_low;
	logic [63:0] raw_high;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] comp_x, comp_y, comp_z, comp_w;
	logic [4:0]  size_bytes;
	logic        format_error;
	int          fail_count;
	int          pending;
	int          send_idle_pct;
	int          stall_pct;

	vertex_attribute_unpack DUT (.*);

	vau_checker checker_i (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver stalls at the rate of the current phase.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// One 16-bit lane, mostly a boundary value, sometimes random.
	function automatic logic [15:0] pick_lane();
		case ($urandom_range(15))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			4: return 16'h8001;
			5: return 16'h7C00;
			6: return 16'hFC00;
			7: return 16'h7E01;
			8: return 16'h0001;
			9: return 16'h03FF;
			10: return 16'h00FF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Present one word and hold it until it is taken.
	task automatic send_word(input logic act, input logic [4:0] fmt, input logic [127:0] raw);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= act;
		attr_format <= fmt;
		raw_low     <= raw[63:0];
		raw_high    <= raw[127:64];
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_random(input int count);
		logic [127:0] raw;
		logic [4:0] fmt;
		for (int n = 0; n < count; n++) begin
			for (int i = 0; i < 8; i++) begin
				raw[16*i +: 16] = ($urandom_range(3) == 0) ? pick_lane() : 16'($urandom);
			end
			fmt = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 17))
				: 5'($urandom_range(16));
			send_word(1'($urandom), fmt, raw);
		end
	endtask

	initial begin
		in_valid      = 1'b0;
		action        = vau_pkg::ACT_VECTOR;
		attr_format   = vau_pkg::FMT_FLOAT1;
		raw_low       = '0;
		raw_high      = '0;
		send_idle_pct = 0;
		stall_pct     = 0;
		arst_n        = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words: every format in both modes, unknown codes, boundary lanes.
		for (int f = 0; f <= 17; f++) begin
			send_word(vau_pkg::ACT_VECTOR, 5'(f), {$urandom, $urandom, $urandom, $urandom});
			send_word(vau_pkg::ACT_COLOR, 5'(f), '1);
		end
		send_word(vau_pkg::ACT_COLOR, 5'd31, '0);
		send_word(vau_pkg::ACT_VECTOR, vau_pkg::FMT_SHORT4N,
			{64'h0, 16'h0, 16'h7FFF, 16'h8001, 16'h8000});
		send_word(vau_pkg::ACT_VECTOR, vau_pkg::FMT_HALF4,
			{64'h0, 16'h0, 16'h0001, 16'h7E00, 16'h8000});
		send_word(vau_pkg::ACT_VECTOR, vau_pkg::FMT_USHORT4N,
			{64'h0, 16'h0, 16'h0001, 16'hFFFF, 16'h8000});
		send_word(vau_pkg::ACT_COLOR, vau_pkg::FMT_COLOR, {96'h0, 32'h01FF_80FE});

		// Random words through the idling and stalling phases.
		send_random(300);
		send_idle_pct = 84;
		send_random(300);
		send_idle_pct = 0;
		stall_pct = 84;
		send_random(300);
		send_idle_pct = 13;
		stall_pct = 13;
		send_random(300);
		send_idle_pct = 0;
		stall_pct = 0;
		send_random(300);
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("vertex_attribute_unpack: match");
		end else begin
			$display("vertex_attribute_unpack: mismatch");
		end
		$finish;
	end

	// Run limit.
	initial begin
		#5ms;
		$display("vertex_attribute_unpack: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/vau_pkg.sv
rtl/core/vau_lane.sv
rtl/core/vertex_attribute_unpack.sv
rtl/core/vau_checker.sv
tb/vau_checker.sv
tb/tb_top.sv
